@@ rtl/core/egcd_pkg.sv @@
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types and constants of the extended gcd unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_BACK,
    ST_SIGN,
    ST_DONE
  } egcd_state_t;

  localparam int unsigned MAX_STEPS = 128;
  localparam int unsigned STEP_W    = 7;

endpackage

@@ rtl/core/extended_gcd_unit_top.sv @@
// Flow: Euclid steps forward through the serial divider, then steps back through
// the serial multiply-subtract over the quotient stack, then a sign fix.
// Throughput: one word at a time; the next is taken after the result leaves.
// Most of the time per word is spent in the bit-serial divider and multiply-subtract.
// Reset: synchronous active-low rst_n clears control; the block returns idle.
// ----------------------------------------------------------------------------
// extended_gcd_unit_top
// Extended Euclid with a quotient stack, shared serial divider and MAC.
// ----------------------------------------------------------------------------
module extended_gcd_unit_top #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_value_a,
  input  logic [DATA_WIDTH-1:0] in_value_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-2:0] out_divisor,
  output logic [DATA_WIDTH-1:0] out_coef_x,
  output logic [DATA_WIDTH-1:0] out_coef_y
);
  import egcd_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  egcd_state_t state_r, state_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, x_r, x_nxt, y_r, y_nxt;
  logic         nega_r, nega_nxt, negb_r, negb_nxt;
  logic [STEP_W:0] n_r, n_nxt;
  logic [W-1:0] qmem [MAX_STEPS];
  logic [W-1:0] qrd_r;
  logic         q_we;
  logic         div_start, div_done, mac_start, mac_done;
  logic [W-1:0] div_q, div_rem, mac_res;
  logic         out_valid_r, out_valid_nxt;
  logic         wait_r, wait_nxt;

  egcd_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(a_r), .divisor(b_r),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  egcd_mac #(.W(W)) u_mac (
    .clk(clk), .rst_n(rst_n), .start(mac_start), .base(x_r), .mult_q(qrd_r),
    .mult_y(y_r), .done(mac_done), .result(mac_res)
  );

  always_ff @(posedge clk) begin
    if (q_we) qmem[n_r[STEP_W-1:0]] <= div_q;
    qrd_r <= qmem[n_nxt[STEP_W-1:0] - 1'b1];
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    a_nxt = a_r; b_nxt = b_r; x_nxt = x_r; y_nxt = y_r;
    nega_nxt = nega_r; negb_nxt = negb_r;
    n_nxt         = n_r;
    q_we          = 1'b0;
    div_start     = 1'b0;
    mac_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    wait_nxt      = 1'b0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          nega_nxt  = in_value_a[W-1];
          negb_nxt  = in_value_b[W-1];
          a_nxt     = in_value_a[W-1] ? (~in_value_a + 1'b1) : in_value_a;
          b_nxt     = in_value_b[W-1] ? (~in_value_b + 1'b1) : in_value_b;
          n_nxt     = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (b_r == '0 || n_r == (STEP_W+1)'(MAX_STEPS)) begin
          x_nxt     = W'(1);
          y_nxt     = '0;
          state_nxt = ST_BACK;
          wait_nxt  = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          q_we      = 1'b1;
          n_nxt     = n_r + 1'b1;
          a_nxt     = b_r;
          b_nxt     = div_rem;
          state_nxt = ST_CHECK;
        end
      end
      ST_BACK: begin
        if (wait_r) begin
          if (n_r == '0) begin
            state_nxt = ST_SIGN;
          end else begin
            mac_start = 1'b1;
            wait_nxt  = 1'b0;
          end
        end else if (mac_done) begin
          x_nxt    = y_r;
          y_nxt    = mac_res;
          n_nxt    = n_r - 1'b1;
          wait_nxt = 1'b1;
        end
      end
      ST_SIGN: begin
        if (!out_valid_r || !out_stall) begin
          if (nega_r) x_nxt = '0 - x_r;
          if (negb_r) y_nxt = '0 - y_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; x_r <= x_nxt; y_r <= y_nxt;
    nega_r <= nega_nxt; negb_r <= negb_nxt;
    n_r <= n_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wait_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wait_r      <= wait_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = a_r[W-2:0];
  assign out_coef_x  = x_r;
  assign out_coef_y  = y_r;

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(x_r) && $stable(y_r)))
    else $error("result changed while stalled");
  a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input open while busy");
  a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV)) else $error("stray divider result");
`endif

endmodule

@@ rtl/core/egcd_divider.sv @@
// ----------------------------------------------------------------------------
// egcd_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module egcd_divider #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  import egcd_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && den_r != '0) |-> (rem_r < den_r)) else $error("remainder too big");
`endif

endmodule

@@ rtl/core/egcd_mac.sv @@
// ----------------------------------------------------------------------------
// egcd_mac
// Bit-serial multiply-subtract: result = t - q*y modulo 2^W, one q bit a cycle.
// ----------------------------------------------------------------------------
module egcd_mac #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] base,
  input  logic [W-1:0] mult_q,
  input  logic [W-1:0] mult_y,
  output logic         done,
  output logic [W-1:0] result
);
  import egcd_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = base;
      q_nxt    = mult_q;
      y_nxt    = mult_y;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (q_r[0]) acc_nxt = acc_r - y_r;
      q_nxt   = {1'b0, q_r[W-1:1]};
      y_nxt   = {y_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1) || q_nxt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("mac done held");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("mac done while busy");
  a_q_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |=> (done_r || q_r != '0)) else $error("mac ran past q");
`endif

endmodule
